@@ rtl/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared assertion wrappers for the closest-pair search block. Defining
// NO_ASSERTIONS turns every use into nothing.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is active.
`define CPBF_ASSERT_IMPL(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("cpbf assertion failed");
// Next-cycle implication, disabled while reset is active.
`define CPBF_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("cpbf assertion failed");
`else
`define CPBF_ASSERT_IMPL(label, ck, rn, ante, cons)
`define CPBF_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

@@ rtl/cpbf_pkg.sv @@
// ============================================================================
// cpbf_pkg
// Types shared by the closest-pair search modules.
// ============================================================================
`default_nettype none

package cpbf_pkg;

  // Control that travels with one pair through the distance pipeline.
  typedef struct packed {
    logic valid;  // a pair is present in this stage
    logic seed;   // starting pair (first point, last point): always taken
    logic last;   // final pair of the scan
  } pair_ctl_t;

endpackage

`default_nettype wire

@@ rtl/cpbf_ifs.sv @@
// ============================================================================
// cpbf channel interfaces
// Valid/ready channels for the point input and the closest-pair result.
// ============================================================================
`default_nettype none

// Point input channel: one transaction per point.
interface cpbf_in_if #(
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  is_final;

  modport source (output valid, output point_x, output point_y, output is_final,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input is_final,
                  output ready);
endinterface

// Result channel: one transaction per point set.
interface cpbf_out_if #(
  parameter int IDX_W      = 6,
  parameter int COORD_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        index_a;
  logic [IDX_W-1:0]        index_b;
  logic [COORD_BITS-1:0]   a_x;
  logic [COORD_BITS-1:0]   a_y;
  logic [COORD_BITS-1:0]   b_x;
  logic [COORD_BITS-1:0]   b_y;
  logic [2*COORD_BITS:0]   dist_squared;
  logic                    overflowed;

  modport source (output valid, output index_a, output index_b, output a_x,
                  output a_y, output b_x, output b_y, output dist_squared,
                  output overflowed, input ready);
  modport sink   (input valid, input index_a, input index_b, input a_x,
                  input a_y, input b_x, input b_y, input dist_squared,
                  input overflowed, output ready);
endinterface

`default_nettype wire

@@ rtl/cpbf_store.sv @@
// ============================================================================
// cpbf_store
// Point store: one write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module cpbf_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; read data is registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/cpbf_dist.sv @@
// ============================================================================
// cpbf_dist
// Three-stage squared-distance pipeline: differences, squares, sum.
// ============================================================================
`default_nettype none

module cpbf_dist import cpbf_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pair_ctl_t               in_ctl,
  input  logic [IDX_W-1:0]        in_ia,
  input  logic [IDX_W-1:0]        in_ib,
  input  logic [2*COORD_BITS-1:0] in_pa,
  input  logic [2*COORD_BITS-1:0] in_pb,
  output pair_ctl_t               res_ctl,
  output logic [IDX_W-1:0]        res_ia,
  output logic [IDX_W-1:0]        res_ib,
  output logic [2*COORD_BITS-1:0] res_pa,
  output logic [2*COORD_BITS-1:0] res_pb,
  output logic [2*COORD_BITS:0]   res_dist
);

  localparam int C = COORD_BITS;

  logic [C-1:0] ax, ay, bx, by;
  logic [C-1:0] dx_nxt, dy_nxt;

  pair_ctl_t          ctl1_r, ctl2_r, ctl3_r;
  logic [IDX_W-1:0]   ia1_r, ib1_r, ia2_r, ib2_r, ia3_r, ib3_r;
  logic [2*C-1:0]     pa1_r, pb1_r, pa2_r, pb2_r, pa3_r, pb3_r;
  logic [C-1:0]       dx1_r, dy1_r;
  logic [2*C-1:0]     sqx2_r, sqy2_r;
  logic [2*C:0]       dist3_r;

  // Absolute coordinate differences.
  assign ax = in_pa[C-1:0];
  assign ay = in_pa[2*C-1:C];
  assign bx = in_pb[C-1:0];
  assign by = in_pb[2*C-1:C];

  always_comb begin
    dx_nxt = (ax >= bx) ? (ax - bx) : (bx - ax);
    dy_nxt = (ay >= by) ? (ay - by) : (by - ay);
  end

  // Control of every stage is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  // Stage 1: differences.
  always_ff @(posedge clk) begin
    ia1_r <= in_ia;
    ib1_r <= in_ib;
    pa1_r <= in_pa;
    pb1_r <= in_pb;
    dx1_r <= dx_nxt;
    dy1_r <= dy_nxt;
  end

  // Stage 2: one multiplier per axis.
  always_ff @(posedge clk) begin
    ia2_r  <= ia1_r;
    ib2_r  <= ib1_r;
    pa2_r  <= pa1_r;
    pb2_r  <= pb1_r;
    sqx2_r <= dx1_r * dx1_r;
    sqy2_r <= dy1_r * dy1_r;
  end

  // Stage 3: sum of squares, one bit wider.
  always_ff @(posedge clk) begin
    ia3_r   <= ia2_r;
    ib3_r   <= ib2_r;
    pa3_r   <= pa2_r;
    pb3_r   <= pb2_r;
    dist3_r <= {1'b0, sqx2_r} + {1'b0, sqy2_r};
  end

  assign res_ctl  = ctl3_r;
  assign res_ia   = ia3_r;
  assign res_ib   = ib3_r;
  assign res_pa   = pa3_r;
  assign res_pb   = pb3_r;
  assign res_dist = dist3_r;

endmodule

`default_nettype wire

@@ rtl/cpbf_seq.sv @@
// ============================================================================
// cpbf_seq
// Sequencer: loads points into the store, walks all pairs through the
// distance pipeline, keeps the best pair and holds the result register.
// ============================================================================
`default_nettype none

module cpbf_seq import cpbf_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  cpbf_in_if.sink                 in_ch,
  cpbf_out_if.source              out_ch,
  // Store ports
  output logic                    mem_we,
  output logic [IDX_W-1:0]        mem_waddr,
  output logic [2*COORD_BITS-1:0] mem_wdata,
  output logic                    mem_re,
  output logic [IDX_W-1:0]        mem_raddr,
  input  logic [2*COORD_BITS-1:0] mem_rdata,
  // Pair into the distance pipeline (point B comes straight from the store)
  output pair_ctl_t               pair_ctl,
  output logic [IDX_W-1:0]        pair_ia,
  output logic [IDX_W-1:0]        pair_ib,
  output logic [2*COORD_BITS-1:0] pair_pa,
  // Distance pipeline result
  input  pair_ctl_t               res_ctl,
  input  logic [IDX_W-1:0]        res_ia,
  input  logic [IDX_W-1:0]        res_ib,
  input  logic [2*COORD_BITS-1:0] res_pa,
  input  logic [2*COORD_BITS-1:0] res_pb,
  input  logic [2*COORD_BITS:0]   res_dist
);

  localparam int C = COORD_BITS;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SEEDA = 3'd1;
  localparam logic [2:0] S_SEEDB = 3'd2;
  localparam logic [2:0] S_ROW   = 3'd3;
  localparam logic [2:0] S_NEXTA = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_POINTS);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             drop_r, drop_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;

  // Tag of the read in flight: point A reload or a pair for the pipeline.
  logic             rd_a_r, rd_a_nxt;
  pair_ctl_t        rd_tag_r, rd_tag_nxt;
  logic [IDX_W-1:0] rd_ia_r, rd_ia_nxt;
  logic [IDX_W-1:0] rd_ib_r, rd_ib_nxt;

  logic [2*C-1:0]   pa_r;

  // Best pair so far.
  logic [IDX_W-1:0] best_ia_r, best_ib_r;
  logic [2*C-1:0]   best_pa_r, best_pb_r;
  logic [2*C:0]     best_dist_r;
  logic             take_best;

  // Result register.
  logic             out_valid_r;
  logic             out_load;
  logic [IDX_W-1:0] out_ia_r, out_ib_r;
  logic [2*C-1:0]   out_pa_r, out_pb_r;
  logic [2*C:0]     out_dist_r;
  logic             out_ovf_r;

  logic             in_fire;
  logic             has_room;
  logic [CNT_W-1:0] n_m1;
  logic             row_end;
  logic             last_row;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign has_room = (count_r < FULL_CNT);
  assign n_m1     = n_r - CNT_W'(1);
  assign row_end  = ((CNT_W'(j_r) + CNT_W'(1)) == n_r);
  assign last_row = ((CNT_W'(i_r) + CNT_W'(2)) == n_r);

  assign in_ch.ready = (state_r == S_LOAD);
  assign mem_wdata   = {in_ch.point_y, in_ch.point_x};
  assign mem_waddr   = count_r[IDX_W-1:0];

  // Next-state and read-issue logic.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    drop_nxt   = drop_r;
    n_nxt      = n_r;
    ovf_nxt    = ovf_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    rd_a_nxt   = 1'b0;
    rd_tag_nxt = '0;
    rd_ia_nxt  = rd_ia_r;
    rd_ib_nxt  = rd_ib_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    out_load   = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          mem_we = has_room;
          if (has_room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_ch.is_final) begin
            n_nxt     = has_room ? (count_r + CNT_W'(1)) : count_r;
            ovf_nxt   = drop_r || !has_room;
            count_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_SEEDA;
          end
        end
      end
      S_SEEDA: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        rd_a_nxt  = 1'b1;
        state_nxt = S_SEEDB;
      end
      S_SEEDB: begin
        mem_re          = 1'b1;
        mem_raddr       = n_m1[IDX_W-1:0];
        rd_tag_nxt.valid = 1'b1;
        rd_tag_nxt.seed  = 1'b1;
        rd_tag_nxt.last  = (n_r == CNT_W'(1));
        rd_ia_nxt       = '0;
        rd_ib_nxt       = n_m1[IDX_W-1:0];
        i_nxt           = '0;
        j_nxt           = IDX_W'(1);
        state_nxt       = (n_r == CNT_W'(1)) ? S_DRAIN : S_ROW;
      end
      S_ROW: begin
        mem_re          = 1'b1;
        mem_raddr       = j_r;
        rd_tag_nxt.valid = 1'b1;
        rd_tag_nxt.last  = row_end && last_row;
        rd_ia_nxt       = i_r;
        rd_ib_nxt       = j_r;
        j_nxt           = j_r + IDX_W'(1);
        if (row_end) begin
          state_nxt = last_row ? S_DRAIN : S_NEXTA;
        end
      end
      S_NEXTA: begin
        mem_re    = 1'b1;
        mem_raddr = i_r + IDX_W'(1);
        rd_a_nxt  = 1'b1;
        i_nxt     = i_r + IDX_W'(1);
        j_nxt     = i_r + IDX_W'(1) + IDX_W'(1);
        state_nxt = S_ROW;
      end
      S_DRAIN: begin
        if (res_ctl.valid && res_ctl.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_load  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      count_r  <= '0;
      drop_r   <= 1'b0;
      n_r      <= '0;
      ovf_r    <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      rd_a_r   <= 1'b0;
      rd_tag_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      drop_r   <= drop_nxt;
      n_r      <= n_nxt;
      ovf_r    <= ovf_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      rd_a_r   <= rd_a_nxt;
      rd_tag_r <= rd_tag_nxt;
    end
  end

  // Pair indices of the read in flight, and point A of the current row.
  always_ff @(posedge clk) begin
    rd_ia_r <= rd_ia_nxt;
    rd_ib_r <= rd_ib_nxt;
    if (rd_a_r) begin
      pa_r <= mem_rdata;
    end
  end

  assign pair_ctl = rd_tag_r;
  assign pair_ia  = rd_ia_r;
  assign pair_ib  = rd_ib_r;
  assign pair_pa  = pa_r;

  // Best pair: the seed is always taken, later pairs only when strictly closer.
  assign take_best = res_ctl.valid && (res_ctl.seed || (res_dist < best_dist_r));

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_ia_r   <= res_ia;
      best_ib_r   <= res_ib;
      best_pa_r   <= res_pa;
      best_pb_r   <= res_pb;
      best_dist_r <= res_dist;
    end
  end

  // Result register, freed when the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ia_r   <= best_ia_r;
      out_ib_r   <= best_ib_r;
      out_pa_r   <= best_pa_r;
      out_pb_r   <= best_pb_r;
      out_dist_r <= best_dist_r;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.index_a      = out_ia_r;
  assign out_ch.index_b      = out_ib_r;
  assign out_ch.a_x          = out_pa_r[C-1:0];
  assign out_ch.a_y          = out_pa_r[2*C-1:C];
  assign out_ch.b_x          = out_pb_r[C-1:0];
  assign out_ch.b_y          = out_pb_r[2*C-1:C];
  assign out_ch.dist_squared = out_dist_r;
  assign out_ch.overflowed   = out_ovf_r;

endmodule

`default_nettype wire

@@ rtl/closest_pair_brute_force.sv @@
// ============================================================================
// closest_pair_brute_force
// Brute-force closest pair of 2-D points by squared Euclidean distance.
// ============================================================================
// Points are loaded one per transaction into a point store with one write
// port and one read port until a transaction marked is_final; points beyond
// MAX_POINTS are dropped and flagged in overflowed. The search then reads the
// store once per pair: one pair enters the three-stage distance pipeline per
// cycle through the store's single read port, except at each row start, where
// the row's first point is fetched instead. Input is refused during the
// search; the result waits in its own register, so the next set can load
// while it is still pending. Ties go to the earliest pair in scan order, and
// the pair (first, last) holds unless a strictly closer pair is found. A
// single point gives the pair (0,0) at distance 0.
`default_nettype none
`include "assert_macros.svh"

module closest_pair_brute_force import cpbf_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cpbf_in_if.sink    in_ch,
  cpbf_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PW    = 2 * COORD_BITS;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [PW-1:0]    mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [PW-1:0]    mem_rdata;

  pair_ctl_t        pair_ctl;
  logic [IDX_W-1:0] pair_ia, pair_ib;
  logic [PW-1:0]    pair_pa;

  pair_ctl_t        res_ctl;
  logic [IDX_W-1:0] res_ia, res_ib;
  logic [PW-1:0]    res_pa, res_pb;
  logic [PW:0]      res_dist;

  // Point store.
  cpbf_store #(
    .DEPTH (MAX_POINTS),
    .WIDTH (PW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Squared-distance pipeline; point B is the store's read data.
  cpbf_dist #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (pair_ctl),
    .in_ia    (pair_ia),
    .in_ib    (pair_ib),
    .in_pa    (pair_pa),
    .in_pb    (mem_rdata),
    .res_ctl  (res_ctl),
    .res_ia   (res_ia),
    .res_ib   (res_ib),
    .res_pa   (res_pa),
    .res_pb   (res_pb),
    .res_dist (res_dist)
  );

  // Load, scan and result control.
  cpbf_seq #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .pair_ctl  (pair_ctl),
    .pair_ia   (pair_ia),
    .pair_ib   (pair_ib),
    .pair_pa   (pair_pa),
    .res_ctl   (res_ctl),
    .res_ia    (res_ia),
    .res_ib    (res_ib),
    .res_pa    (res_pa),
    .res_pb    (res_pb),
    .res_dist  (res_dist)
  );

  // No point is taken while pairs are being scanned.
  `CPBF_ASSERT_IMPL(a_no_load_in_scan, clk, rst_n, pair_ctl.valid, !in_ch.ready)
  // Scanned pairs are always ordered first index below second.
  `CPBF_ASSERT_IMPL(a_pair_order, clk, rst_n, pair_ctl.valid && !pair_ctl.seed, pair_ia < pair_ib)
  // The seed pair always starts from the first point.
  `CPBF_ASSERT_IMPL(a_seed_first, clk, rst_n, pair_ctl.valid && pair_ctl.seed, pair_ia == '0)
  // Nothing follows the last pair of a scan.
  `CPBF_ASSERT_NEXT(a_last_ends, clk, rst_n, pair_ctl.valid && pair_ctl.last, !pair_ctl.valid)

endmodule

`default_nettype wire

@@ test/tb_closest_pair_brute_force.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closest-pair search testbench
// Loads point sets into the brute-force closest-pair block through its
// valid/ready channels. It predicts each set's closest pair, distance and
// drop flag, and checks every result transaction against that prediction.
// ----------------------------------------------------------------------------

module tb_closest_pair_brute_force;

  localparam int N_PTS        = 64;
  localparam int CB           = 16;
  localparam int IDX_W        = 6;
  localparam int DW           = 2 * CB + 1;
  localparam int TOTAL_ITEMS  = 1900;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES  = 2200;
  localparam int HOLD_CYCLES  = 500;
  localparam int IDLE_PCT     = 22;

  // One point transaction as queued for the driver.
  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          fin;
    logic          drain;  // wait until every pending result is back
  } point_t;

  // One closest-pair result.
  typedef struct packed {
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [CB-1:0]    a_x;
    logic [CB-1:0]    a_y;
    logic [CB-1:0]    b_x;
    logic [CB-1:0]    b_y;
    logic [2*CB:0]    dist_squared;
    logic             overflowed;
  } pair_result_t;

  logic clk;
  logic rst_n;

  cpbf_in_if  #(.COORD_BITS(CB))                in_ch ();
  cpbf_out_if #(.IDX_W(IDX_W), .COORD_BITS(CB)) out_ch ();

  closest_pair_brute_force #(
    .MAX_POINTS(N_PTS),
    .COORD_BITS(CB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  point_t       point_queue[$];
  pair_result_t expected_pairs[$];
  point_t       cur_pt;

  // Predictor state: the point store and the current set's bookkeeping.
  logic [CB-1:0] pts_x[N_PTS];
  logic [CB-1:0] pts_y[N_PTS];
  int            pt_count = 0;
  logic          pt_dropped = 1'b0;

  int    items_sent = 0;
  int    finals_sent = 0;
  int    results_got = 0;
  int    errors = 0;
  int    cycles = 0;
  int    hold_left;
  int    holds_done;
  int    sets_total;
  int    sets_over;

  // Squared distance between two stored points, one bit wider than needed.
  function automatic logic [2*CB+1:0] sq_gap(input int i, input int j);
    logic [CB-1:0]     dx;
    logic [CB-1:0]     dy;
    logic [2*CB+1:0]   sum;
    dx  = (pts_x[i] >= pts_x[j]) ? pts_x[i] - pts_x[j] : pts_x[j] - pts_x[i];
    dy  = (pts_y[i] >= pts_y[j]) ? pts_y[i] - pts_y[j] : pts_y[j] - pts_y[i];
    sum = (DW+1)'(dx) * (DW+1)'(dx) + (DW+1)'(dy) * (DW+1)'(dy);
    return sum;
  endfunction

  // Stores one accepted point; on the last point of a set, searches all
  // pairs and queues the expected closest pair.
  task automatic store_point(input point_t p);
    pair_result_t     r;
    int               n;
    int               bi;
    int               bj;
    logic [2*CB+1:0]  best;
    logic [2*CB+1:0]  d;
    if (pt_count < N_PTS) begin
      pts_x[pt_count] = p.x;
      pts_y[pt_count] = p.y;
      pt_count++;
    end else begin
      pt_dropped = 1'b1;
    end
    if (p.fin) begin
      n    = pt_count;
      bi   = 0;
      bj   = n - 1;
      best = sq_gap(bi, bj);
      // Scan order i then j; only a strictly smaller distance replaces the
      // starting pair (first, last), so the earliest tie wins.
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          d = sq_gap(i, j);
          if (d < best) begin
            best = d;
            bi   = i;
            bj   = j;
          end
        end
      end
      r.index_a      = bi[IDX_W-1:0];
      r.index_b      = bj[IDX_W-1:0];
      r.a_x          = pts_x[bi];
      r.a_y          = pts_y[bi];
      r.b_x          = pts_x[bj];
      r.b_y          = pts_y[bj];
      r.dist_squared = best[2*CB:0];
      r.overflowed   = pt_dropped;
      expected_pairs.insert(expected_pairs.size(), r);
      pt_count   = 0;
      pt_dropped = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [2*CB:0] want,
                             input logic [2*CB:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("Mismatch on %s after %0d results: expected %0d, got %0d",
                 name, results_got, want, got);
    end
  endtask

  task automatic add_point(input logic [CB-1:0] x, input logic [CB-1:0] y,
                           input logic fin, input logic drain);
    point_t p;
    p.x     = x;
    p.y     = y;
    p.fin   = fin;
    p.drain = drain;
    point_queue.insert(point_queue.size(), p);
    if (fin) sets_total++;
  endtask

  // Draws one coordinate; the modes favor duplicates, ties and extremes.
  function automatic logic [CB-1:0] pick_coord(input int mode, input int base);
    logic [CB-1:0] v;
    case (mode)
      0: v = CB'($urandom);
      1: v = CB'($urandom_range(0, 3) * 21845);
      2: v = CB'(base + $urandom_range(0, 15));
      default: v = $urandom_range(0, 1) ? {CB{1'b1}} : '0;
    endcase
    return v;
  endfunction

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, finals_sent - results_got);
      $display("[closest_pair_brute_force] ERROR");
      $finish;
    end
  end

  // Point driver: presents queued points, idling at random, and feeds every
  // accepted transaction to the predictor.
  always @(posedge clk) begin
    logic took;
    logic go;
    logic steady;
    int   awaiting;
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.point_x  <= '0;
      in_ch.point_y  <= '0;
      in_ch.is_final <= 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        store_point(cur_pt);
        items_sent <= items_sent + 1;
        if (cur_pt.fin) finals_sent <= finals_sent + 1;
      end
      awaiting = finals_sent - results_got + ((took && cur_pt.fin) ? 1 : 0);
      if (!in_ch.valid || took) begin
        steady = (items_sent >= 900) && (items_sent < 1200);
        go = (point_queue.size() != 0) &&
             !(point_queue[0].drain && awaiting != 0) &&
             (steady || $urandom_range(0, 99) >= IDLE_PCT);
        if (go) begin
          cur_pt = point_queue.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.point_x  <= cur_pt.x;
          in_ch.point_y  <= cur_pt.y;
          in_ch.is_final <= cur_pt.fin;
        end else begin
          // Idle cycle: junk payload with valid low.
          in_ch.valid    <= 1'b0;
          in_ch.point_x  <= CB'($urandom);
          in_ch.point_y  <= CB'($urandom);
          in_ch.is_final <= 1'($urandom_range(0, 1));
        end
      end
    end
  end

  // Receiver hold-off: twice, refuse results for a long stretch so that the
  // block fills up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && results_got >= (holds_done == 0 ? 30 : 140)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Result monitor: checks each result transaction against the oldest
  // expected pair and drives ready.
  always @(posedge clk) begin
    pair_result_t want;
    logic         steady;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pairs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Result with no expected pair: index_a %0d index_b %0d dist %0d",
                     out_ch.index_a, out_ch.index_b, out_ch.dist_squared);
        end else begin
          want = expected_pairs.pop_front();
          check_field("index_a", DW'(want.index_a), DW'(out_ch.index_a));
          check_field("index_b", DW'(want.index_b), DW'(out_ch.index_b));
          check_field("a_x", DW'(want.a_x), DW'(out_ch.a_x));
          check_field("a_y", DW'(want.a_y), DW'(out_ch.a_y));
          check_field("b_x", DW'(want.b_x), DW'(out_ch.b_x));
          check_field("b_y", DW'(want.b_y), DW'(out_ch.b_y));
          check_field("dist_squared", want.dist_squared, out_ch.dist_squared);
          check_field("overflowed", DW'(want.overflowed), DW'(out_ch.overflowed));
        end
        results_got <= results_got + 1;
      end
      steady = (results_got >= 60) && (results_got < 100);
      out_ch.ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int size;
    int mode;
    int base;
    int set_no;
    int missing;
    rst_n          = 1'b0;
    sets_total     = 0;
    sets_over      = 0;

    // Single points at both corners.
    add_point(16'h0000, 16'h0000, 1'b1, 1'b0);
    add_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    // Two points at the largest possible distance, both diagonals.
    add_point(16'h0000, 16'h0000, 1'b0, 1'b0);
    add_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    add_point(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    add_point(16'h0000, 16'hFFFF, 1'b1, 1'b0);
    // Square: all sides tie, so the starting pair (first, last) must hold.
    add_point(16'd100, 16'd100, 1'b0, 1'b0);
    add_point(16'd200, 16'd100, 1'b0, 1'b0);
    add_point(16'd200, 16'd200, 1'b0, 1'b0);
    add_point(16'd100, 16'd200, 1'b1, 1'b0);
    // A strictly closer pair in the middle of the set.
    add_point(16'd0, 16'd0, 1'b0, 1'b0);
    add_point(16'd1000, 16'd1000, 1'b0, 1'b0);
    add_point(16'd1001, 16'd1000, 1'b0, 1'b0);
    add_point(16'd5000, 16'd5000, 1'b1, 1'b0);
    // Duplicate points beat a starting pair at distance one.
    add_point(16'd7, 16'd7, 1'b0, 1'b0);
    add_point(16'd300, 16'd5, 1'b0, 1'b0);
    add_point(16'd300, 16'd5, 1'b0, 1'b0);
    add_point(16'd7, 16'd8, 1'b1, 1'b0);
    // Alternating bit patterns.
    add_point(16'hAAAA, 16'h5555, 1'b0, 1'b0);
    add_point(16'h5555, 16'hAAAA, 1'b0, 1'b0);
    add_point(16'hFFFF, 16'h0000, 1'b1, 1'b0);

    // Random sets: mostly small, a few that fill or overflow the store.
    set_no = 0;
    while (point_queue.size() < TOTAL_ITEMS) begin
      mode = $urandom_range(0, 3);
      base = $urandom_range(0, 65520);
      if (set_no == 5) size = N_PTS;
      else if (set_no == 10) size = N_PTS + 2;
      else if ($urandom_range(0, 99) < 4) size = $urandom_range(N_PTS - 4, N_PTS + 6);
      else if ($urandom_range(0, 99) < 20) size = $urandom_range(1, 3);
      else size = $urandom_range(2, 16);
      if (size > N_PTS) sets_over++;
      for (int k = 0; k < size; k++)
        add_point(pick_coord(mode, base), pick_coord(mode, base), k == size - 1,
                  k == 0 && set_no % 40 == 20);
      set_no++;
    end
    size = point_queue.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (items_sent != size) @(posedge clk);
    while (finals_sent != results_got) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    missing = expected_pairs.size();
    if (missing != 0) begin
      $display("%0d expected pairs never arrived", missing);
    end
    $display("Loaded %0d points in %0d sets, %0d of them past the store depth.",
             items_sent, sets_total, sets_over);
    $display("Checked %0d closest-pair results; %0d errors.", results_got,
             errors + missing);
    if (errors == 0 && missing == 0) begin
      $display("[closest_pair_brute_force] OK");
    end else begin
      $display("[closest_pair_brute_force] ERROR");
    end
    $finish;
  end

endmodule
